FILE: rtl/core/wrs_pkg.sv
// Shared constants and types for the weighted random selector.
// Used by every module under rtl/core; depends on nothing.
package wrs_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int RAND_BITS   = 16;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int TOT_W = WEIGHT_BITS + IDX_W;
	localparam int PRD_W = RAND_BITS + TOT_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	localparam logic REG_COUNT_IN_USE = 1'b0;

	typedef struct packed {
		logic                   en;
		logic [IDX_W-1:0]       addr;
		logic [WEIGHT_BITS-1:0] data;
	} tbl_wr_t;

endpackage

FILE: rtl/core/wrs_table.sv
// Weight table: one write port, one read port, cleared to zero at reset.
// Depends on wrs_pkg.
module wrs_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wrs_pkg::tbl_wr_t               wr,
	input  logic [wrs_pkg::IDX_W-1:0]       rd_addr,
	output logic [wrs_pkg::WEIGHT_BITS-1:0] rd_data
);
	import wrs_pkg::*;

	logic [WEIGHT_BITS-1:0] mem_q [MAX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = mem_q[rd_addr];

endmodule

FILE: rtl/core/wrs_alu.sv
// Shared adder and comparator used by both the sum pass and the scan pass.
// Depends on wrs_pkg.
module wrs_alu (
	input  logic [wrs_pkg::TOT_W-1:0]       acc,
	input  logic [wrs_pkg::WEIGHT_BITS-1:0] weight,
	input  logic [wrs_pkg::TOT_W-1:0]       scaled,
	output logic [wrs_pkg::TOT_W-1:0]       sum,
	output logic                            hit
);
	import wrs_pkg::*;

	assign sum = acc + TOT_W'(weight);
	assign hit = (scaled < sum);

endmodule

FILE: rtl/core/wrs_seq.sv
// Draw sequencer: sums the weights in use, scales the random word, then scans.
// Depends on wrs_pkg and wrs_alu; drives the wrs_table ports.
module wrs_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            op,
	input  logic [wrs_pkg::IDX_W-1:0]       entry_index,
	input  logic [wrs_pkg::WEIGHT_BITS-1:0] weight_value,
	input  logic [wrs_pkg::RAND_BITS-1:0]   random_word,
	input  logic [wrs_pkg::CNT_W-1:0]       count,
	output logic                            busy,
	output wrs_pkg::tbl_wr_t                tbl_wr,
	output logic [wrs_pkg::IDX_W-1:0]       rd_addr,
	input  logic [wrs_pkg::WEIGHT_BITS-1:0] rd_data,
	output logic                            done,
	output logic [wrs_pkg::IDX_W-1:0]       chosen_index,
	output logic                            no_choice
);
	import wrs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     n_q;
	logic [TOT_W-1:0]     acc_q;
	logic [TOT_W-1:0]     scaled_q;
	logic [RAND_BITS-1:0] rand_q;
	logic                 done_q;
	logic [IDX_W-1:0]     chosen_q;
	logic                 no_choice_q;

	logic                 accept;
	logic [CNT_W-1:0]     n_sat;
	logic [TOT_W-1:0]     sum;
	logic                 hit;
	logic [PRD_W-1:0]     prod;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign n_sat   = (count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count;
	assign rd_addr = idx_q[IDX_W-1:0];
	assign prod    = PRD_W'(rand_q) * PRD_W'(acc_q);

	always_comb begin
		tbl_wr.en   = accept && (op == OP_WRITE) &&
		              (CNT_W'(entry_index) < CNT_W'(MAX_ENTRIES));
		tbl_wr.addr = entry_index;
		tbl_wr.data = weight_value;
	end

	wrs_alu u_alu (
		.acc    (acc_q),
		.weight (rd_data),
		.scaled (scaled_q),
		.sum    (sum),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_DRAW)) begin
						idx_q   <= '0;
						n_q     <= n_sat;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (idx_q == n_q) begin
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MUL: begin
					idx_q <= '0;
					if (acc_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// last entry in use also ends the scan
					if (hit || (idx_q == n_q - 1'b1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
				if (accept) begin
					rand_q <= random_word;
				end
			end
			ST_SUM: begin
				if (idx_q != n_q) begin
					acc_q <= sum;
				end
			end
			ST_MUL: begin
				scaled_q    <= prod[RAND_BITS +: TOT_W];
				acc_q       <= '0;
				no_choice_q <= (acc_q == '0);
				chosen_q    <= '0;
			end
			ST_SCAN: begin
				acc_q    <= sum;
				chosen_q <= idx_q[IDX_W-1:0];
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign done         = done_q;
	assign chosen_index = chosen_q;
	assign no_choice    = no_choice_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while a draw is still running");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < n_q))
		else $error("scan index past the entries in use");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (idx_q <= n_q))
		else $error("sum index past the entries in use");

endmodule

FILE: rtl/core/weighted_random_selector_unit.sv
// Weighted random selector: roulette-wheel pick over a table of weights.
// Depends on wrs_pkg, wrs_table, wrs_seq (which holds wrs_alu).
//
// Usage:
//   Items enter on start while busy is low. op = 0 writes weight_value into
//   entry entry_index without raising busy and gives no result. op = 1 is a draw:
//   the first count_in_use weights (capped at 16) are summed, random_word is
//   scaled by the total, and the first entry whose running sum exceeds the
//   scaled value is picked.
//   A draw whose total is zero skips the scan and sets no_choice.
//   One adder and comparator walk the table one entry per cycle, twice.
//   The result shows on chosen_index / no_choice with done high for exactly
//   one cycle, in the same cycle that busy falls; the receiver cannot stall it,
//   and a new item may start in that same cycle.
//   count_in_use sits at APB byte address 0; write it only while idle.
//   Reset clears every weight to zero and sets count_in_use to 16.
module weighted_random_selector_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            op,
	input  logic [wrs_pkg::IDX_W-1:0]       entry_index,
	input  logic [wrs_pkg::WEIGHT_BITS-1:0] weight_value,
	input  logic [wrs_pkg::RAND_BITS-1:0]   random_word,
	output logic                            done,
	output logic [wrs_pkg::IDX_W-1:0]       chosen_index,
	output logic                            no_choice,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import wrs_pkg::*;

	logic [CNT_W-1:0]       count_q;
	logic                   reg_wr;
	tbl_wr_t                tbl_wr;
	logic [IDX_W-1:0]       rd_addr;
	logic [WEIGHT_BITS-1:0] rd_data;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COUNT_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_ENTRIES);
		end else if (reg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_COUNT_IN_USE) ? 32'(count_q) : '0;

	wrs_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wrs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.entry_index  (entry_index),
		.weight_value (weight_value),
		.random_word  (random_word),
		.count        (count_q),
		.busy         (busy),
		.tbl_wr       (tbl_wr),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.done         (done),
		.chosen_index (chosen_index),
		.no_choice    (no_choice)
	);

endmodule
